// File: sv/sob_pkg.sv
// ----------------------------------------------------------------------------
// sob_pkg
// Shared types and constants for the source-over pixel blender.
// ----------------------------------------------------------------------------
package sob_pkg;

	typedef enum logic [1:0] {
		FMT_ALPHA8   = 2'd0,
		FMT_GREY8    = 2'd1,
		FMT_RGBA8888 = 2'd2
	} fmt_t;

	typedef enum logic [1:0] {
		REG_SOURCE_FORMAT = 2'd0,
		REG_TARGET_FORMAT = 2'd1
	} reg_idx_t;

	localparam int NW = 17;
	localparam int QDepth = 2;
	localparam int QPtrW = $clog2(QDepth);
	localparam int QCntW = $clog2(QDepth + 1);

	localparam logic [15:0] W_RED = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE = 16'd4732;
	localparam logic [33:0] LUM_HALF = 34'd8355840;
	localparam logic [18:0] RECIP_255 = 19'd263173;
	localparam int RECIP_SHIFT = 26;

	typedef struct packed {
		logic [1:0]             fmt;
		logic [3:0][NW-1:0]     n;
	} sob_entry_t;

	function automatic logic [7:0] sat_byte(input logic [10:0] q);
		return (q > 11'd255) ? 8'hff : q[7:0];
	endfunction

endpackage

// File: sv/srcover_pixel_blend.sv
// ----------------------------------------------------------------------------
// srcover_pixel_blend
// Premultiplied source-over blend of one source and one destination pixel.
// ----------------------------------------------------------------------------
// One pixel pair is taken per request and one blended pixel comes out per
// request, at one pixel per clock while the output side keeps ready high.
// The front unpacks both pixels and forms the exact blend sums in the cycle
// of the request, then a two-entry queue feeds a four-stage back pipeline
// (rounding multiply, luminance sum, luminance rounding multiply, output
// register). Formats are 0 alpha8, 1 grey8, 2 rgba8888; code 3 acts as
// rgba8888. Write the format registers only while no request is in flight.
module srcover_pixel_blend import sob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] source_pixel, [63:32] dest_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] blended_pixel
);

	sob_entry_t entry;
	sob_entry_t q_data;
	logic q_full;
	logic q_empty;
	logic q_pop;

	assign s_tready = !q_full;

	sob_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.source_pixel (s_tdata[31:0]),
		.dest_pixel   (s_tdata[63:32]),
		.entry        (entry)
	);

	sob_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid),
		.push_data (entry),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.pop_data  (q_data)
	);

	sob_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// File: sv/sob_front.sv
// ----------------------------------------------------------------------------
// sob_front
// Holds the format registers, unpacks both pixels and forms the exact
// per-channel blend sums src*255 + dst*(255 - src_alpha).
// ----------------------------------------------------------------------------
module sob_front import sob_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_data,
	input  logic [31:0]       source_pixel,
	input  logic [31:0]       dest_pixel,
	output sob_entry_t        entry
);

	logic [1:0] src_fmt_q;
	logic [1:0] dst_fmt_q;
	logic [3:0][7:0] s_ch;
	logic [3:0][7:0] d_ch;
	logic [7:0] inv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= FMT_RGBA8888;
			dst_fmt_q <= FMT_RGBA8888;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_FORMAT: src_fmt_q <= cfg_data;
				REG_TARGET_FORMAT: dst_fmt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic logic [3:0][7:0] unpack_px(input logic [1:0] fmt,
		input logic [31:0] px);
		logic [3:0][7:0] ch;
		case (fmt)
			FMT_ALPHA8: ch = {px[7:0], 8'd0, 8'd0, 8'd0};
			FMT_GREY8:  ch = {8'hff, px[7:0], px[7:0], px[7:0]};
			default:    ch = px;
		endcase
		return ch;
	endfunction

	always_comb begin
		s_ch = unpack_px(src_fmt_q, source_pixel);
		d_ch = unpack_px(dst_fmt_q, dest_pixel);
		inv = 8'hff - s_ch[3];
		entry.fmt = dst_fmt_q;
		for (int i = 0; i < 4; i++) begin
			entry.n[i] = NW'(s_ch[i]) * NW'(255) + NW'(d_ch[i]) * NW'(inv);
		end
	end

endmodule

// File: sv/sob_queue.sv
// ----------------------------------------------------------------------------
// sob_queue
// Short queue between the front and the back pipeline.
// ----------------------------------------------------------------------------
module sob_queue import sob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sob_entry_t  push_data,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output sob_entry_t  pop_data
);

	sob_entry_t mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == QCntW'(QDepth));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("queue count out of range");

	a_push_only: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop && !do_push |=> count_q == $past(count_q) - 1'b1)
		else $error("queue count missed a pop");

endmodule

// File: sv/sob_back.sv
// ----------------------------------------------------------------------------
// sob_back
// Rounds the blend sums to bytes, forms Rec.709 luminance for grey
// targets and packs the result in the target format.
// ----------------------------------------------------------------------------
module sob_back import sob_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  sob_entry_t  q_data,
	output logic        q_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata
);

	logic en;
	logic vld_s1, vld_s2, vld_s3, m_valid_q;
	logic [1:0] fmt_s1, fmt_s2, fmt_s3;
	logic [3:0][36:0] cprod_s1;
	logic [32:0] pr_s1, pg_s1, pb_s1;
	logic [3:0][7:0] ch_s2, ch_s3;
	logic [17:0] gx_s2;
	logic [36:0] gprod_s3;
	logic [33:0] lum;
	logic [31:0] data_q;

	assign en = !m_valid_q || m_tready;
	assign q_pop = en && !q_empty;
	assign lum = 34'(pr_s1) + 34'(pg_s1) + 34'(pb_s1) + LUM_HALF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= !q_empty;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			m_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s1 <= q_data.fmt;
			for (int i = 0; i < 4; i++) begin
				cprod_s1[i] <= 37'(18'(q_data.n[i]) + 18'd127) * 37'(RECIP_255);
			end
			pr_s1 <= 33'(q_data.n[0]) * 33'(W_RED);
			pg_s1 <= 33'(q_data.n[1]) * 33'(W_GREEN);
			pb_s1 <= 33'(q_data.n[2]) * 33'(W_BLUE);

			fmt_s2 <= fmt_s1;
			for (int i = 0; i < 4; i++) begin
				ch_s2[i] <= sat_byte(cprod_s1[i][36:RECIP_SHIFT]);
			end
			gx_s2 <= lum[33:16];

			fmt_s3 <= fmt_s2;
			ch_s3 <= ch_s2;
			gprod_s3 <= 37'(gx_s2) * 37'(RECIP_255);

			case (fmt_s3)
				FMT_ALPHA8: data_q <= {24'd0, ch_s3[3]};
				FMT_GREY8:  data_q <= {24'd0, sat_byte(gprod_s3[36:RECIP_SHIFT])};
				default:    data_q <= ch_s3;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = data_q;

endmodule
